[rtl/permutation_parity_assert.svh]
// Assertion macros shared by the permutation parity checker.
`ifndef PERMUTATION_PARITY_ASSERT_SVH
`define PERMUTATION_PARITY_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define PP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("permutation parity check failed");

// Consequent checked at the edge after the antecedent.
`define PP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("permutation parity check failed");

`endif

[rtl/pp_pkg.sv]
// Shared types and constants of the permutation parity block.
package pp_pkg;

    // Fixed field widths.
    localparam int LEN_W  = 9;
    localparam int ELEM_W = 16;
    localparam int RES_W  = 2;

    // Result codes.
    localparam logic [RES_W-1:0] RES_EVEN    = 2'b01;
    localparam logic [RES_W-1:0] RES_ODD     = 2'b11;
    localparam logic [RES_W-1:0] RES_INVALID = 2'b00;

    // Result request from the sequencer to the output stage.
    typedef struct packed {
        logic             load;
        logic [RES_W-1:0] value;
    } res_req_t;

endpackage

[rtl/pp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read of an address written in
    // the same cycle returns the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pp_core.sv]
// Sequencer: loads elements into the stores, walks the cycles, clears flags.
module pp_core #(
    parameter int MAX_LENGTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pp_pkg::LEN_W-1:0]          cfg_wr_data,
    input  logic                              elem_valid,
    output logic                              elem_stall,
    input  logic [pp_pkg::ELEM_W-1:0]         element_value,
    output logic                              seen_we,
    output logic [$clog2(MAX_LENGTH)-1:0]     seen_waddr,
    output logic                              seen_wdata,
    output logic [$clog2(MAX_LENGTH)-1:0]     seen_raddr,
    input  logic                              seen_rdata,
    output logic                              perm_we,
    output logic [$clog2(MAX_LENGTH)-1:0]     perm_waddr,
    output logic [$clog2(MAX_LENGTH)-1:0]     perm_wdata,
    output logic [$clog2(MAX_LENGTH)-1:0]     perm_raddr,
    input  logic [$clog2(MAX_LENGTH)-1:0]     perm_rdata,
    output pp_pkg::res_req_t                  res_req,
    input  logic                              res_free
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);
    localparam int SW = ((CW > pp_pkg::ELEM_W) ? CW : pp_pkg::ELEM_W) + 2;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LENGTH - 1);

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_LOAD,
        ST_CHECK,
        ST_SCAN,
        ST_TEST,
        ST_FOLLOW,
        ST_EMIT
    } state_t;

    state_t        state_reg,   state_next;
    logic [CW-1:0] n_reg,       n_next;
    logic [CW-1:0] count_reg,   count_next;
    logic          invalid_reg, invalid_next;
    logic          cyc_reg,     cyc_next;
    logic [AW-1:0] idx_reg,     idx_next;
    logic [AW-1:0] start_reg,   start_next;
    logic [AW-1:0] k_reg,       k_next;
    logic          kok_reg,     kok_next;

    logic [SW-1:0] elem_ext;
    logic [SW-1:0] n_ext;
    logic [SW-1:0] k_sum;
    logic          k_ok;
    logic [AW-1:0] last_idx;
    logic          bad;
    logic          store_ok;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] n_cfg;

    // Fold a negative element into range and check it against the length.
    always_comb
    begin
        elem_ext = {{(SW - pp_pkg::ELEM_W){element_value[pp_pkg::ELEM_W-1]}}, element_value};
        n_ext    = {{(SW - CW){1'b0}}, n_reg};
        k_sum    = elem_ext + (element_value[pp_pkg::ELEM_W-1] ? n_ext : {SW{1'b0}});
        k_ok     = !k_sum[SW-1] && (k_sum < n_ext);
    end

    // Active length from a written register value: zero acts as one and
    // anything beyond the store depth is clamped to it.
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            n_cfg = CW'(1);
        end
        else if (32'(cfg_wr_data) > MAX_LENGTH)
        begin
            n_cfg = CW'(MAX_LENGTH);
        end
        else
        begin
            n_cfg = CW'(cfg_wr_data);
        end
    end

    assign last_idx  = AW'(n_reg - CW'(1));
    assign count_inc = count_reg + CW'(1);
    assign bad       = !kok_reg || seen_rdata;
    assign store_ok  = (state_reg == ST_CHECK) && !bad;
    assign elem_stall = (state_reg != ST_LOAD);

    // Memory port steering.
    always_comb
    begin
        seen_we    = 1'b0;
        seen_waddr = idx_reg;
        seen_wdata = 1'b0;
        seen_raddr = idx_reg;
        perm_we    = store_ok;
        perm_waddr = count_reg[AW-1:0];
        perm_wdata = k_reg;
        perm_raddr = idx_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                seen_we = 1'b1;
            end
            ST_LOAD:
            begin
                seen_raddr = k_sum[AW-1:0];
            end
            ST_CHECK:
            begin
                seen_we    = !bad;
                seen_waddr = k_reg;
                seen_wdata = 1'b1;
            end
            ST_TEST:
            begin
                seen_raddr = idx_reg + AW'(1);
                seen_we    = seen_rdata;
            end
            ST_FOLLOW:
            begin
                seen_we    = (perm_rdata != start_reg);
                seen_waddr = perm_rdata;
                perm_raddr = perm_rdata;
            end
            default:
            begin
                seen_we = 1'b0;
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        count_next   = count_reg;
        invalid_next = invalid_reg;
        cyc_next     = cyc_reg;
        idx_next     = idx_reg;
        start_next   = start_reg;
        k_next       = k_reg;
        kok_next     = kok_reg;
        res_req.load  = 1'b0;
        res_req.value = pp_pkg::RES_INVALID;

        case (state_reg)
            // Clear every seen flag, one entry a cycle.
            ST_SWEEP:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_ADDR)
                begin
                    state_next = ST_LOAD;
                end
            end
            // Take one element request and look up its seen flag.
            ST_LOAD:
            begin
                if (elem_valid)
                begin
                    k_next     = k_sum[AW-1:0];
                    kok_next   = k_ok;
                    state_next = ST_CHECK;
                end
            end
            // Mark the element, count it, and close the permutation.
            ST_CHECK:
            begin
                invalid_next = invalid_reg | bad;
                if (count_inc == n_reg)
                begin
                    count_next = '0;
                    idx_next   = '0;
                    state_next = (invalid_reg | bad) ? ST_EMIT : ST_SCAN;
                end
                else
                begin
                    count_next = count_inc;
                    state_next = ST_LOAD;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_TEST;
            end
            // A set flag opens a new cycle; a clear one moves to the next entry.
            ST_TEST:
            begin
                if (seen_rdata)
                begin
                    cyc_next   = !cyc_reg;
                    start_next = idx_reg;
                    state_next = ST_FOLLOW;
                end
                else if (idx_reg == last_idx)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            // Follow the cycle through the store until it returns to its start.
            ST_FOLLOW:
            begin
                if (perm_rdata == start_reg)
                begin
                    if (idx_reg == last_idx)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            // Hand the result to the output stage once it has room.
            ST_EMIT:
            begin
                if (res_free)
                begin
                    res_req.load = 1'b1;
                    if (invalid_reg)
                    begin
                        res_req.value = pp_pkg::RES_INVALID;
                        state_next    = ST_SWEEP;
                    end
                    else if (n_reg[0] ^ cyc_reg)
                    begin
                        res_req.value = pp_pkg::RES_ODD;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        res_req.value = pp_pkg::RES_EVEN;
                        state_next    = ST_LOAD;
                    end
                    idx_next     = '0;
                    invalid_next = 1'b0;
                    cyc_next     = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
                idx_next   = '0;
            end
        endcase

        // A length write drops the permutation in progress.
        if (cfg_wr_en)
        begin
            n_next       = n_cfg;
            count_next   = '0;
            invalid_next = 1'b0;
            cyc_next     = 1'b0;
            idx_next     = '0;
            state_next   = ST_SWEEP;
        end
    end

    // State and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SWEEP;
            n_reg       <= CW'(1);
            count_reg   <= '0;
            invalid_reg <= 1'b0;
            cyc_reg     <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            count_reg   <= count_next;
            invalid_reg <= invalid_next;
            cyc_reg     <= cyc_next;
            idx_reg     <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        k_reg     <= k_next;
        kok_reg   <= kok_next;
    end

endmodule

[rtl/pp_out.sv]
// Output register that holds one result request until it is taken.
module pp_out (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pp_pkg::res_req_t          res_req,
    output logic                      res_free,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [pp_pkg::RES_W-1:0]  parity_result
);

    logic                     valid_reg, valid_next;
    logic [pp_pkg::RES_W-1:0] data_reg,  data_next;

    // The slot is free when empty or being taken in this cycle.
    assign res_free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_req.load)
        begin
            valid_next = 1'b1;
            data_next  = res_req.value;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid  = valid_reg;
    assign parity_result = data_reg;

endmodule

[rtl/permutation_parity.sv]
// Top level of the permutation parity block.
//
//   channel  direction  handshake               payload
//   element  in         elem_valid/elem_stall   element_value (16 bits, signed)
//   result   out        result_valid/result_stall parity_result (2 bits, result code)
//   config   in         cfg_wr_en               cfg_wr_data (9 bits)
//
// Loading an element reads the seen flag memory, then writes it; the next element
// is not taken before the write. After the last element, the cycle walk scans the
// seen flags and follows each cycle found through the permutation store.
// Reset, a length write and an invalid permutation start a clearing pass over
// every entry of the seen flag memory, during which no element is taken.
// A result waiting on result_stall holds the walk only when the next result is due.
module permutation_parity #(
    parameter int MAX_LENGTH = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [pp_pkg::LEN_W-1:0]  cfg_wr_data,
    input  logic                      elem_valid,
    output logic                      elem_stall,
    input  logic [pp_pkg::ELEM_W-1:0] element_value,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [pp_pkg::RES_W-1:0]  parity_result
);

    localparam int AW = $clog2(MAX_LENGTH);

    logic          seen_we;
    logic [AW-1:0] seen_waddr;
    logic          seen_wdata;
    logic [AW-1:0] seen_raddr;
    logic          seen_rdata;
    logic          perm_we;
    logic [AW-1:0] perm_waddr;
    logic [AW-1:0] perm_wdata;
    logic [AW-1:0] perm_raddr;
    logic [AW-1:0] perm_rdata;

    pp_pkg::res_req_t res_req;
    logic             res_free;

    // Sequencer.
    pp_core #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .elem_valid    (elem_valid),
        .elem_stall    (elem_stall),
        .element_value (element_value),
        .seen_we       (seen_we),
        .seen_waddr    (seen_waddr),
        .seen_wdata    (seen_wdata),
        .seen_raddr    (seen_raddr),
        .seen_rdata    (seen_rdata),
        .perm_we       (perm_we),
        .perm_waddr    (perm_waddr),
        .perm_wdata    (perm_wdata),
        .perm_raddr    (perm_raddr),
        .perm_rdata    (perm_rdata),
        .res_req       (res_req),
        .res_free      (res_free)
    );

    // Seen flag memory, one bit per value.
    pp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LENGTH)
    ) u_seen_ram (
        .clk   (clk),
        .we    (seen_we),
        .waddr (seen_waddr),
        .wdata (seen_wdata),
        .raddr (seen_raddr),
        .rdata (seen_rdata)
    );

    // Permutation store, one element per position.
    pp_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_LENGTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rdata)
    );

    // Output register.
    pp_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_req       (res_req),
        .res_free      (res_free),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .parity_result (parity_result)
    );

endmodule

[rtl/pp_check.sv]
// Port-level assertion checker for the permutation parity block, with its bind.
`include "permutation_parity_assert.svh"

module pp_check (
    input logic       clk,
    input logic       rst_n,
    input logic       elem_valid,
    input logic       elem_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [1:0] parity_result
);

    // A stalled result request stays offered.
    `PP_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid)

    // A stalled result keeps its value.
    `PP_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(parity_result))

    // Each taken element is followed by a flag update before the next is taken.
    `PP_ASSERT_NEXT(a_elem_gap, elem_valid && !elem_stall, elem_stall)

    // A result never appears in the cycle right after an element is taken.
    `PP_ASSERT_SAME(a_res_latency, $rose(result_valid), !$past(elem_valid && !elem_stall))

endmodule

bind permutation_parity pp_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .elem_valid    (elem_valid),
    .elem_stall    (elem_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .parity_result (parity_result)
);
